// ----- hw/rtl/srfe_pkg.sv -----
package srfe_pkg;

    localparam int unsigned MAX_DIM = 1048576;

    localparam logic [1:0] MODE_ROW    = 2'd0;
    localparam logic [1:0] MODE_ENTRY  = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    localparam logic REG_COLUMN_COUNT  = 1'b0;
    localparam logic REG_EXCLUDE_EMPTY = 1'b1;

    localparam logic [20:0] MAX_DIM_W = 21'(MAX_DIM);

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] len;
        logic [41:0] len_sq;
        logic [19:0] col;
    } srfe_item_t;

    typedef struct packed {
        logic [20:0] column_count;
        logic        exclude_empty;
    } srfe_cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [41:0] divisor;
    } srfe_div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } srfe_div_resp_t;

    typedef struct packed {
        logic [40:0] total_nonzeros;
        logic [20:0] row_total;
        logic [20:0] empty_row_total;
        logic [20:0] longest_row;
        logic [36:0] mean_fixed;
        logic [36:0] deviation_fixed;
        logic [36:0] variation_fixed;
        logic [36:0] band_fixed;
        logic [20:0] diagonal_total;
        logic [20:0] degree_average;
        logic [16:0] density_fixed;
        logic        not_square;
    } srfe_result_t;

endpackage

// ----- hw/rtl/srfe_div.sv -----
module srfe_div
    import srfe_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  srfe_div_req_t  req,
    output srfe_div_resp_t resp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [41:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [41:0] divisor_reg, divisor_next;
    logic        zero_reg, zero_next;
    logic [42:0] shifted;
    logic [42:0] diff;

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        zero_next    = zero_reg;
        shifted      = {rem_reg, quo_reg[63]};
        diff         = shifted - {1'b0, divisor_reg};
        if (req.start) begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
            zero_next    = (req.divisor == '0);
        end else if (busy_reg) begin
            if (!diff[42]) begin
                rem_next = diff[41:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted[41:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        zero_reg    <= zero_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = zero_reg ? 64'd0 : quo_reg;

endmodule

// ----- hw/rtl/srfe_front.sv -----
module srfe_front
    import srfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [20:0] s_row_length,
    input  logic [19:0] s_col_index,
    output logic        push,
    output srfe_item_t  push_item,
    input  logic        queue_full
);

    logic       valid_reg, valid_next;
    srfe_item_t item_reg, item_next;
    logic [20:0] len_clamped;
    logic        useful;

    assign push    = valid_reg && !queue_full;
    assign s_ready = !valid_reg || !queue_full;
    assign useful  = (s_mode == MODE_ROW) || (s_mode == MODE_ENTRY) || (s_mode == MODE_FINISH);
    assign len_clamped = (s_row_length > MAX_DIM_W) ? MAX_DIM_W : s_row_length;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (push) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next       = useful;
            item_next.kind   = s_mode;
            item_next.len    = len_clamped;
            item_next.len_sq = {21'd0, len_clamped} * {21'd0, len_clamped};
            item_next.col    = s_col_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign push_item = item_reg;

endmodule

// ----- hw/rtl/srfe_fifo.sv -----
module srfe_fifo
    import srfe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  srfe_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output srfe_item_t head
);

    srfe_item_t  mem_reg [4];
    logic [1:0]  wr_reg, wr_next;
    logic [1:0]  rd_reg, rd_next;
    logic [2:0]  count_reg, count_next;

    assign full      = (count_reg == 3'd4);
    assign not_empty = (count_reg != 3'd0);
    assign head      = mem_reg[rd_reg];

    always_comb begin
        wr_next    = push ? wr_reg + 2'd1 : wr_reg;
        rd_next    = pop ? rd_reg + 2'd1 : rd_reg;
        count_next = count_reg + {2'd0, push} - {2'd0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/srfe_back.sv -----
module srfe_back
    import srfe_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  srfe_cfg_t    cfg,
    input  logic         q_not_empty,
    input  srfe_item_t   q_head,
    output logic         q_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output srfe_result_t m_result
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_DQ = 3'd1;
    localparam logic [2:0] ST_MUL_SS = 3'd2;
    localparam logic [2:0] ST_SQRT   = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    localparam logic [2:0] DIV_MEAN = 3'd0;
    localparam logic [2:0] DIV_DEV  = 3'd1;
    localparam logic [2:0] DIV_COV  = 3'd2;
    localparam logic [2:0] DIV_BAND = 3'd3;
    localparam logic [2:0] DIV_DEG  = 3'd4;
    localparam logic [2:0] DIV_DENS = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [20:0] rows_reg, rows_next;
    logic [20:0] nonempty_reg, nonempty_next;
    logic [39:0] sum_reg, sum_next;
    logic [60:0] sqsum_reg, sqsum_next;
    logic [20:0] maxlen_reg, maxlen_next;
    logic [19:0] maxdist_reg, maxdist_next;
    logic [20:0] diag_reg, diag_next;

    logic [81:0] prod_reg, prod_next;
    logic [81:0] mcand_reg, mcand_next;
    logic [40:0] mplier_reg, mplier_next;
    logic [81:0] dq_reg, dq_next;
    logic [41:0] nc_reg, nc_next;
    logic [113:0] rad_reg, rad_next;
    logic [58:0] rem_reg, rem_next;
    logic [56:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  div_idx_reg, div_idx_next;
    logic        issued_reg, issued_next;

    logic         m_valid_reg, m_valid_next;
    srfe_result_t res_reg, res_next;
    srfe_result_t out_reg, out_next;

    srfe_div_req_t  div_req;
    srfe_div_resp_t div_resp;

    logic [20:0] divisor_d;
    logic        square;
    logic [19:0] cur_row;
    logic [19:0] gap;
    logic [58:0] rem_sh;
    logic [58:0] trial;
    logic [58:0] rem_diff;
    logic [81:0] var_diff;
    logic [40:0] sum_diag;
    logic        out_load;

    assign divisor_d = cfg.exclude_empty ? nonempty_reg : rows_reg;
    assign square    = (rows_reg == cfg.column_count);
    assign cur_row   = 20'(rows_reg - 21'd1);
    assign gap       = (q_head.col > cur_row) ? q_head.col - cur_row : cur_row - q_head.col;
    assign rem_sh    = {rem_reg[56:0], rad_reg[113:112]};
    assign trial     = {root_reg, 2'b01};
    assign rem_diff  = rem_sh - trial;
    assign var_diff  = dq_reg - prod_reg;
    assign sum_diag  = {1'b0, sum_reg} + {20'd0, diag_reg};
    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        div_req.start    = (state_reg == ST_DIV) && !issued_reg;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (div_idx_reg)
            DIV_MEAN: begin
                div_req.dividend = {8'd0, sum_reg, 16'd0};
                div_req.divisor  = {21'd0, divisor_d};
            end
            DIV_DEV: begin
                div_req.dividend = {7'd0, root_reg};
                div_req.divisor  = {21'd0, divisor_d};
            end
            DIV_COV: begin
                div_req.dividend = {7'd0, root_reg};
                div_req.divisor  = {2'd0, sum_reg};
            end
            DIV_BAND: begin
                div_req.dividend = {28'd0, maxdist_reg, 16'd0};
                div_req.divisor  = {21'd0, rows_reg};
            end
            DIV_DEG: begin
                div_req.dividend = {23'd0, sum_diag};
                div_req.divisor  = {21'd0, rows_reg};
            end
            DIV_DENS: begin
                div_req.dividend = {8'd0, sum_reg, 16'd0};
                div_req.divisor  = nc_reg;
            end
            default: begin
                div_req.dividend = '0;
                div_req.divisor  = '0;
            end
        endcase
    end

    srfe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    always_comb begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        nonempty_next = nonempty_reg;
        sum_next      = sum_reg;
        sqsum_next    = sqsum_reg;
        maxlen_next   = maxlen_reg;
        maxdist_next  = maxdist_reg;
        diag_next     = diag_reg;
        prod_next     = prod_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        dq_next       = dq_reg;
        nc_next       = nc_reg;
        rad_next      = rad_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        cnt_next      = cnt_reg;
        div_idx_next  = div_idx_reg;
        issued_next   = issued_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    case (q_head.kind)
                        MODE_ROW: begin
                            if (rows_reg != MAX_DIM_W) begin
                                rows_next = rows_reg + 21'd1;
                                if (q_head.len != '0) begin
                                    nonempty_next = nonempty_reg + 21'd1;
                                end
                                sum_next   = sum_reg + {19'd0, q_head.len};
                                sqsum_next = sqsum_reg + {19'd0, q_head.len_sq};
                                if (q_head.len > maxlen_reg) begin
                                    maxlen_next = q_head.len;
                                end
                            end
                        end
                        MODE_ENTRY: begin
                            if (rows_reg != '0) begin
                                if (gap > maxdist_reg) begin
                                    maxdist_next = gap;
                                end
                                if (gap == '0 && diag_reg != '1) begin
                                    diag_next = diag_reg + 21'd1;
                                end
                            end
                        end
                        MODE_FINISH: begin
                            prod_next   = '0;
                            mcand_next  = {21'd0, sqsum_reg};
                            mplier_next = {20'd0, divisor_d};
                            nc_next     = {21'd0, rows_reg} * {21'd0, cfg.column_count};
                            state_next  = ST_MUL_DQ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL_DQ, ST_MUL_SS: begin
                if (mplier_reg == '0) begin
                    if (state_reg == ST_MUL_DQ) begin
                        dq_next     = prod_reg;
                        prod_next   = '0;
                        mcand_next  = {42'd0, sum_reg};
                        mplier_next = {1'b0, sum_reg};
                        state_next  = ST_MUL_SS;
                    end else begin
                        rad_next   = (prod_reg <= dq_reg) ? {var_diff, 32'd0} : '0;
                        rem_next   = '0;
                        root_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_SQRT;
                    end
                end else begin
                    if (mplier_reg[0]) begin
                        prod_next = prod_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[80:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[40:1]};
                end
            end
            ST_SQRT: begin
                rad_next = {rad_reg[111:0], 2'b00};
                if (!rem_diff[58] && rem_sh >= trial) begin
                    rem_next  = rem_diff;
                    root_next = {root_reg[55:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[55:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd56) begin
                    div_idx_next = DIV_MEAN;
                    issued_next  = 1'b0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!issued_reg) begin
                    issued_next = 1'b1;
                end else if (div_resp.done) begin
                    issued_next  = 1'b0;
                    div_idx_next = div_idx_reg + 3'd1;
                    case (div_idx_reg)
                        DIV_MEAN: res_next.mean_fixed      = div_resp.quotient[36:0];
                        DIV_DEV:  res_next.deviation_fixed = div_resp.quotient[36:0];
                        DIV_COV:  res_next.variation_fixed = div_resp.quotient[36:0];
                        DIV_BAND: res_next.band_fixed      = div_resp.quotient[36:0];
                        DIV_DEG: begin
                            if (!square) begin
                                res_next.degree_average = '0;
                            end else if (div_resp.quotient[63:21] != '0) begin
                                res_next.degree_average = '1;
                            end else begin
                                res_next.degree_average = div_resp.quotient[20:0];
                            end
                        end
                        DIV_DENS: begin
                            if (div_resp.quotient[63:17] != '0) begin
                                res_next.density_fixed = '1;
                            end else begin
                                res_next.density_fixed = div_resp.quotient[16:0];
                            end
                            state_next = ST_OUT;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    out_next                 = res_reg;
                    out_next.total_nonzeros  = {1'b0, sum_reg};
                    out_next.row_total       = rows_reg;
                    out_next.empty_row_total = rows_reg - nonempty_reg;
                    out_next.longest_row     = maxlen_reg;
                    out_next.diagonal_total  = square ? diag_reg : 21'd0;
                    out_next.not_square      = !square;
                    m_valid_next             = 1'b1;
                    rows_next                = '0;
                    nonempty_next            = '0;
                    sum_next                 = '0;
                    sqsum_next               = '0;
                    maxlen_next              = '0;
                    maxdist_next             = '0;
                    diag_next                = '0;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rows_reg     <= '0;
            nonempty_reg <= '0;
            sum_reg      <= '0;
            sqsum_reg    <= '0;
            maxlen_reg   <= '0;
            maxdist_reg  <= '0;
            diag_reg     <= '0;
            issued_reg   <= 1'b0;
            div_idx_reg  <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            nonempty_reg <= nonempty_next;
            sum_reg      <= sum_next;
            sqsum_reg    <= sqsum_next;
            maxlen_reg   <= maxlen_next;
            maxdist_reg  <= maxdist_next;
            diag_reg     <= diag_next;
            issued_reg   <= issued_next;
            div_idx_reg  <= div_idx_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dq_reg     <= dq_next;
        nc_reg     <= nc_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

    a_rows_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_reg <= MAX_DIM_W)
        else $error("row count beyond limit");

    a_nonempty_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nonempty_reg <= rows_reg)
        else $error("non-empty rows exceed rows");

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> state_reg == ST_DIV)
        else $error("divider started outside divide phase");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_resp.done |-> state_reg == ST_DIV && issued_reg)
        else $error("unexpected divider result");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> rows_reg == '0 && sum_reg == '0 && m_valid_reg)
        else $error("state not cleared after result");

endmodule

// ----- hw/rtl/sparse_row_feature_extractor.sv -----
// sparse row feature extractor
// input words arrive on s_valid/s_ready with s_mode, s_row_length and
// s_col_index: a row word opens the next row, an entry word gives one column
// of the current row, a finish word produces one result word on m_valid/m_ready
// and clears the accumulated statistics (configuration is kept)
// configuration: cfg_write with cfg_index 0 sets column_count, 1 sets
// exclude_empty; write only while the block is idle
// row and entry words are taken at one per cycle through a four-word queue
// and are absorbed with no output
// a finish word takes roughly 460 to 520 cycles in the back end: a bit-serial
// multiplier (one cycle per multiplier bit, up to 21 + 40), a 57-step square
// root and six 64-step divisions through one shared restoring divider (66
// cycles each); words queue up behind it meanwhile
// the result sits in an output register until taken; while it waits, the next
// matrix keeps streaming in, and the following finish holds until it drains
// reset (aresetn, synchronous, active low) clears all counts, empties the queue
// and sets column_count to 1 and exclude_empty to 0
module sparse_row_feature_extractor
    import srfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [20:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [20:0] s_row_length,
    input  logic [19:0] s_col_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [40:0] m_total_nonzeros,
    output logic [20:0] m_row_total,
    output logic [20:0] m_empty_row_total,
    output logic [20:0] m_longest_row,
    output logic [36:0] m_mean_fixed,
    output logic [36:0] m_deviation_fixed,
    output logic [36:0] m_variation_fixed,
    output logic [36:0] m_band_fixed,
    output logic [20:0] m_diagonal_total,
    output logic [20:0] m_degree_average,
    output logic [16:0] m_density_fixed,
    output logic        m_not_square
);

    srfe_cfg_t    cfg_reg;
    logic         push;
    srfe_item_t   push_item;
    logic         queue_full;
    logic         q_pop;
    logic         q_not_empty;
    srfe_item_t   q_head;
    srfe_result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.column_count  <= 21'd1;
            cfg_reg.exclude_empty <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_COLUMN_COUNT:  cfg_reg.column_count  <= cfg_data;
                REG_EXCLUDE_EMPTY: cfg_reg.exclude_empty <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    srfe_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_row_length (s_row_length),
        .s_col_index  (s_col_index),
        .push         (push),
        .push_item    (push_item),
        .queue_full   (queue_full)
    );

    srfe_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    srfe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (result)
    );

    assign m_total_nonzeros  = result.total_nonzeros;
    assign m_row_total       = result.row_total;
    assign m_empty_row_total = result.empty_row_total;
    assign m_longest_row     = result.longest_row;
    assign m_mean_fixed      = result.mean_fixed;
    assign m_deviation_fixed = result.deviation_fixed;
    assign m_variation_fixed = result.variation_fixed;
    assign m_band_fixed      = result.band_fixed;
    assign m_diagonal_total  = result.diagonal_total;
    assign m_degree_average  = result.degree_average;
    assign m_density_fixed   = result.density_fixed;
    assign m_not_square      = result.not_square;

endmodule

// ----- verif/sparse_row_feature_extractor_test.sv -----
`timescale 1ns / 1ps

module sparse_row_feature_extractor_test;
    import srfe_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_write;
    logic        cfg_index;
    logic [20:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [20:0] s_row_length;
    logic [19:0] s_col_index;
    logic        m_valid;
    logic        m_ready;
    srfe_result_t got;

    sparse_row_feature_extractor u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_row_length      (s_row_length),
        .s_col_index       (s_col_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_total_nonzeros  (got.total_nonzeros),
        .m_row_total       (got.row_total),
        .m_empty_row_total (got.empty_row_total),
        .m_longest_row     (got.longest_row),
        .m_mean_fixed      (got.mean_fixed),
        .m_deviation_fixed (got.deviation_fixed),
        .m_variation_fixed (got.variation_fixed),
        .m_band_fixed      (got.band_fixed),
        .m_diagonal_total  (got.diagonal_total),
        .m_degree_average  (got.degree_average),
        .m_density_fixed   (got.density_fixed),
        .m_not_square      (got.not_square)
    );

    localparam int SETTLE_CYCLES = 700;

    // statistics model state
    logic [20:0]  cur_columns;
    logic         cur_exclude;
    logic [20:0]  acc_rows;
    logic [20:0]  acc_nonempty;
    logic [39:0]  acc_sum;
    logic [60:0]  acc_sq_sum;
    logic [20:0]  acc_longest;
    logic [19:0]  acc_distance;
    logic [20:0]  acc_diagonal;

    srfe_result_t stats_q[$];
    int           error_count;
    int           words_sent;
    bit           send_idle;
    bit           recv_idle;
    int           hold_cycles;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] isqrt(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (({64'b0, t} * {64'b0, t}) <= x) r = t;
        end
        return r;
    endfunction

    task automatic clear_stats();
        acc_rows = '0; acc_nonempty = '0; acc_sum = '0; acc_sq_sum = '0;
        acc_longest = '0; acc_distance = '0; acc_diagonal = '0;
    endtask

    function automatic srfe_result_t matrix_summary();
        srfe_result_t e;
        logic [63:0]  n, s, d, root, dev, mean, cov, band, diag, deg, dens;
        logic [127:0] dq, ss, v;
        logic         square;
        n = 64'(acc_rows);
        s = 64'(acc_sum);
        d = cur_exclude ? 64'(acc_nonempty) : n;
        square = (n == 64'(cur_columns));
        dq = 128'(d) * 128'(acc_sq_sum);
        ss = 128'(s) * 128'(s);
        root = '0; mean = '0; dev = '0; cov = '0; band = '0;
        diag = '0; deg = '0; dens = '0;
        if (ss <= dq) begin
            v = (dq - ss) << 32;
            root = isqrt(v);
        end
        if (d != 0) begin
            mean = (s << 16) / d;
            dev = root / d;
        end
        if (d != 0 && s != 0) cov = root / s;
        if (n != 0) band = (64'(acc_distance) << 16) / n;
        if (square) begin
            diag = 64'(acc_diagonal);
            if (n != 0) begin
                deg = (s + 64'(acc_diagonal)) / n;
                if (deg > 64'h1FFFFF) deg = 64'h1FFFFF;
            end
        end
        if (n != 0 && cur_columns != 0) begin
            dens = (s << 16) / (n * 64'(cur_columns));
            if (dens > 64'h1FFFF) dens = 64'h1FFFF;
        end
        e.total_nonzeros  = 41'(s);
        e.row_total       = 21'(n);
        e.empty_row_total = acc_rows - acc_nonempty;
        e.longest_row     = acc_longest;
        e.mean_fixed      = 37'(mean);
        e.deviation_fixed = 37'(dev);
        e.variation_fixed = 37'(cov);
        e.band_fixed      = 37'(band);
        e.diagonal_total  = 21'(diag);
        e.degree_average  = 21'(deg);
        e.density_fixed   = 17'(dens);
        e.not_square      = !square;
        return e;
    endfunction

    task automatic absorb_word(logic [1:0] mode, logic [20:0] len, logic [19:0] col);
        logic [20:0] l;
        logic [20:0] row;
        logic [20:0] gap;
        if (mode == MODE_ROW) begin
            if (acc_rows < MAX_DIM_W) begin
                l = (len > MAX_DIM_W) ? MAX_DIM_W : len;
                acc_rows = acc_rows + 1'b1;
                if (l != 0) acc_nonempty = acc_nonempty + 1'b1;
                acc_sum = acc_sum + 40'(l);
                acc_sq_sum = acc_sq_sum + 61'(42'(l) * 42'(l));
                if (l > acc_longest) acc_longest = l;
            end
        end else if (mode == MODE_ENTRY) begin
            if (acc_rows != 0) begin
                row = acc_rows - 1'b1;
                gap = (21'(col) > row) ? 21'(col) - row : row - 21'(col);
                if (gap > 21'(acc_distance)) acc_distance = 20'(gap);
                if (gap == 0 && acc_diagonal != 21'h1FFFFF)
                    acc_diagonal = acc_diagonal + 1'b1;
            end
        end else if (mode == MODE_FINISH) begin
            stats_q.push_back(matrix_summary());
            clear_stats();
        end
    endtask

    task automatic send_word(logic [1:0] mode, logic [20:0] len, logic [19:0] col);
        if (send_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_row_length <= len;
        s_col_index <= col;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_word(mode, len, col);
        words_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (stats_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [20:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_write <= 1'b0;
        @(posedge aclk);
        if (idx == REG_COLUMN_COUNT) cur_columns = value;
        else cur_exclude = value[0];
    endtask

    task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] want);
        if (error_count < 40)
            $display("mismatch %s: got %0d expected %0d", field, seen, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        srfe_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (stats_q.size() == 0) begin
                report_mismatch("unexpected word", 64'd1, 64'd0);
            end else begin
                e = stats_q.pop_front();
                if (got.total_nonzeros != e.total_nonzeros)
                    report_mismatch("total_nonzeros", got.total_nonzeros, e.total_nonzeros);
                if (got.row_total != e.row_total)
                    report_mismatch("row_total", got.row_total, e.row_total);
                if (got.empty_row_total != e.empty_row_total)
                    report_mismatch("empty_row_total", got.empty_row_total,
                                    e.empty_row_total);
                if (got.longest_row != e.longest_row)
                    report_mismatch("longest_row", got.longest_row, e.longest_row);
                if (got.mean_fixed != e.mean_fixed)
                    report_mismatch("mean_fixed", got.mean_fixed, e.mean_fixed);
                if (got.deviation_fixed != e.deviation_fixed)
                    report_mismatch("deviation_fixed", got.deviation_fixed,
                                    e.deviation_fixed);
                if (got.variation_fixed != e.variation_fixed)
                    report_mismatch("variation_fixed", got.variation_fixed,
                                    e.variation_fixed);
                if (got.band_fixed != e.band_fixed)
                    report_mismatch("band_fixed", got.band_fixed, e.band_fixed);
                if (got.diagonal_total != e.diagonal_total)
                    report_mismatch("diagonal_total", got.diagonal_total, e.diagonal_total);
                if (got.degree_average != e.degree_average)
                    report_mismatch("degree_average", got.degree_average, e.degree_average);
                if (got.density_fixed != e.density_fixed)
                    report_mismatch("density_fixed", got.density_fixed, e.density_fixed);
                if (got.not_square != e.not_square)
                    report_mismatch("not_square", got.not_square, e.not_square);
            end
        end
    end

    // result side back-pressure
    initial begin
        int burst;
        burst = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if (recv_idle && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic random_matrix(int nrows);
        logic [20:0] len;
        int          ents;
        int          pick;
        logic [19:0] col;
        for (int r = 0; r < nrows; r++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) len = 21'($urandom);
            else if (pick == 1) len = MAX_DIM_W;
            else len = 21'($urandom_range(0, 6));
            if ($urandom_range(0, 29) == 0) send_word(2'd3, 21'($urandom), 20'($urandom));
            send_word(MODE_ROW, len, 20'($urandom));
            ents = (len > 4) ? $urandom_range(0, 4) : int'(len);
            for (int k = 0; k < ents; k++) begin
                pick = $urandom_range(0, 5);
                if (pick < 2) col = 20'(r);
                else if (pick < 4) col = 20'(r + $urandom_range(0, 3)) - 20'd1;
                else col = 20'($urandom);
                send_word(MODE_ENTRY, 21'($urandom), col);
            end
        end
        send_word(MODE_FINISH, 21'($urandom), 20'($urandom));
    endtask

    task automatic test_directed();
        // entry before any row, unused mode, empty matrix
        send_word(MODE_ENTRY, 21'h1FFFFF, 20'hFFFFF);
        send_word(2'd3, 21'h1FFFFF, 20'hFFFFF);
        send_word(MODE_FINISH, 21'h0, 20'h0);
        // rows of zero, clamped and extreme length
        send_word(MODE_ROW, 21'h0, 20'h0);
        send_word(MODE_ROW, 21'h1FFFFF, 20'h0);
        send_word(MODE_ENTRY, 21'h0, 20'h1);
        send_word(MODE_ENTRY, 21'h0, 20'hFFFFF);
        send_word(MODE_ROW, MAX_DIM_W, 20'h0);
        send_word(MODE_ENTRY, 21'h0, 20'h0);
        send_word(MODE_FINISH, 21'h0, 20'h0);
        // single diagonal entry, square with column_count reset value
        send_word(MODE_ROW, 21'd1, 20'h0);
        send_word(MODE_ENTRY, 21'h0, 20'h0);
        send_word(MODE_FINISH, 21'h0, 20'h0);
        // all rows empty
        send_word(MODE_ROW, 21'd0, 20'h0);
        send_word(MODE_ROW, 21'd0, 20'h0);
        send_word(MODE_FINISH, 21'h0, 20'h0);
        settle();
        write_reg(REG_EXCLUDE_EMPTY, 21'd1);
        write_reg(REG_COLUMN_COUNT, 21'd3);
        send_word(MODE_ROW, 21'd0, 20'h0);
        send_word(MODE_ROW, 21'd0, 20'h0);
        send_word(MODE_FINISH, 21'h0, 20'h0);
        send_word(MODE_ROW, 21'd2, 20'h0);
        send_word(MODE_ENTRY, 21'h0, 20'h0);
        send_word(MODE_ROW, 21'd0, 20'h0);
        send_word(MODE_ROW, 21'd5, 20'h0);
        send_word(MODE_ENTRY, 21'h0, 20'h2);
        send_word(MODE_FINISH, 21'h0, 20'h0);
        settle();
    endtask

    task automatic test_random();
        int base;
        while (words_sent < 600) begin
            base = $urandom_range(0, 3);
            if (base == 0) write_reg(REG_COLUMN_COUNT, 21'd1);
            else if (base == 1) write_reg(REG_COLUMN_COUNT, MAX_DIM_W);
            else write_reg(REG_COLUMN_COUNT, 21'($urandom_range(1, 8)));
            write_reg(REG_EXCLUDE_EMPTY, 21'($urandom_range(0, 1)));
            repeat (6) begin
                if ($urandom_range(0, 2) != 0 && cur_columns <= 8)
                    random_matrix(int'(cur_columns));
                else
                    random_matrix($urandom_range(0, 8));
            end
            settle();
        end
    endtask

    task automatic test_pressure();
        hold_cycles = 4000;
        repeat (5) random_matrix(int'(cur_columns) > 8 ? 4 : int'(cur_columns));
        settle();
    endtask

    task automatic test_no_idle();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        write_reg(REG_COLUMN_COUNT, 21'd4);
        write_reg(REG_EXCLUDE_EMPTY, 21'd0);
        repeat (8) random_matrix($urandom_range(3, 5));
        settle();
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_COLUMN_COUNT;
        cfg_data = '0;
        s_valid = 1'b0;
        s_mode = MODE_ROW;
        s_row_length = '0;
        s_col_index = '0;
        error_count = 0;
        words_sent = 0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        hold_cycles = 0;
        cur_columns = 21'd1;
        cur_exclude = 1'b0;
        clear_stats();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        words_sent = 0;
        test_random();
        test_pressure();
        test_no_idle();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
